### rtl/i2cs_pkg.sv
// ----------------------------------------------------------------------------
// i2cs_pkg: shared types and constants of the I2C transaction sequencer
// Item, result and control encodings used by the front end, back end and top.
// ----------------------------------------------------------------------------
package i2cs_pkg;

  localparam int unsigned QueueDepthDef = 8;
  localparam int unsigned ByteDepthDef  = 64;
  localparam int unsigned EntryW        = 23;

  typedef enum logic [1:0] {
    MODE_SUBMIT = 2'd0,
    MODE_PUSH   = 2'd1,
    MODE_EVENT  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_ADDR_W  = 4'd2,
    PH_WRITE   = 4'd3,
    PH_RESTART = 4'd4,
    PH_ADDR_R  = 4'd5,
    PH_READ    = 4'd6,
    PH_STOP    = 4'd7,
    PH_DONE    = 4'd8,
    PH_ERROR   = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_TX      = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_RCV     = 3'd3,
    CMD_ACK     = 3'd4,
    CMD_NACK    = 3'd5,
    CMD_STOP    = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  // control_busy bit positions
  localparam int unsigned CbStart   = 0;
  localparam int unsigned CbRestart = 1;
  localparam int unsigned CbStop    = 2;
  localparam int unsigned CbAck     = 3;
  localparam int unsigned CbRcv     = 4;

  typedef struct packed {
    mode_e       mode;
    logic        empty_xfer;
    logic [6:0]  dev_addr;
    logic [7:0]  write_count;
    logic [7:0]  read_count;
    logic [7:0]  data_byte;
    logic [4:0]  control_busy;
    logic        transmit_busy;
    logic        nack_seen;
    logic        rx_full;
    logic        stop_seen;
  } item_t;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  tx_byte;
    logic        issue_start;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        done_res;
    logic        success;
    logic        retrigger;
    logic        busy_res;
    status_e     request_status;
  } result_t;

endpackage

### rtl/i2cs_ram.sv
// ----------------------------------------------------------------------------
// i2cs_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module i2cs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/i2cs_front.sv
// ----------------------------------------------------------------------------
// i2cs_front: input stage of the sequencer
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module i2cs_front import i2cs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  item_t      item_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       item_pop_i
);

  item_t      buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      cls;

  always_comb begin
    cls = item_i;
    cls.empty_xfer = (item_i.write_count == 8'd0) && (item_i.read_count == 8'd0);
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (item_pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_pop_i};
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_i |-> item_valid_o) else $error("pop from empty item queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("item queue count out of range");
  a_full_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !in_ready_o) else $error("ready while queue full");
`endif

endmodule

### rtl/i2cs_back.sv
// ----------------------------------------------------------------------------
// i2cs_back: execution stage of the sequencer
// Runs the transaction phases, owns the request and byte stores, and holds
// the result register toward the output channel.
// ----------------------------------------------------------------------------
module i2cs_back import i2cs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH      = QueueDepthDef,
  parameter int unsigned BYTE_STORE_DEPTH = ByteDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  localparam int unsigned QW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QFW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BW  = $clog2(BYTE_STORE_DEPTH);
  localparam int unsigned BFW = $clog2(BYTE_STORE_DEPTH + 1);
  localparam int unsigned NW  = (BFW > 8) ? BFW : 8;

  phase_e         phase_q, phase_d;
  logic           inprog_q, inprog_d;
  logic [6:0]     addr_q, addr_d;
  logic [7:0]     wtot_q, wtot_d, wdone_q, wdone_d;
  logic [7:0]     rtot_q, rtot_d, rdone_q, rdone_d;
  logic [QW-1:0]  qhead_q, qhead_d, qtail_q, qtail_d;
  logic [QFW-1:0] qfill_q, qfill_d;
  logic [BW-1:0]  bhead_q, bhead_d, btail_q, btail_d;
  logic [BFW-1:0] bfill_q, bfill_d;
  logic           out_valid_q;
  result_t        res_q, res_d;

  logic              q_we, b_we;
  logic [EntryW-1:0] q_wdata, q_rdata, q_head_data;
  logic [7:0]        b_rdata, b_head_data;
  logic              q_fwd_q, b_fwd_q;
  logic [EntryW-1:0] q_fwd_data_q;
  logic [7:0]        b_fwd_data_q;

  logic [7:0]    rem;
  logic [NW-1:0] ndisc;
  logic [NW:0]   hsum;
  logic [7:0]    rd_next;

  assign item_pop_o  = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign q_wdata = {item_i.dev_addr, item_i.write_count, item_i.read_count};

  // stores read the next head each cycle; a same-cycle write is forwarded
  i2cs_ram #(.WIDTH(EntryW), .DEPTH(QUEUE_DEPTH)) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (qtail_q),
    .wdata_i (q_wdata),
    .raddr_i (qhead_d),
    .rdata_o (q_rdata)
  );

  i2cs_ram #(.WIDTH(8), .DEPTH(BYTE_STORE_DEPTH)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (btail_q),
    .wdata_i (item_i.data_byte),
    .raddr_i (bhead_d),
    .rdata_o (b_rdata)
  );

  always_ff @(posedge clk_i) begin
    q_fwd_data_q <= q_wdata;
    b_fwd_data_q <= item_i.data_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_fwd_q <= 1'b0;
      b_fwd_q <= 1'b0;
    end else begin
      q_fwd_q <= q_we && (qtail_q == qhead_d);
      b_fwd_q <= b_we && (btail_q == bhead_d);
    end
  end

  assign q_head_data = q_fwd_q ? q_fwd_data_q : q_rdata;
  assign b_head_data = b_fwd_q ? b_fwd_data_q : b_rdata;

  always_comb begin
    phase_d  = phase_q;
    inprog_d = inprog_q;
    addr_d   = addr_q;
    wtot_d   = wtot_q;
    wdone_d  = wdone_q;
    rtot_d   = rtot_q;
    rdone_d  = rdone_q;
    qhead_d  = qhead_q;
    qtail_d  = qtail_q;
    qfill_d  = qfill_q;
    bhead_d  = bhead_q;
    btail_d  = btail_q;
    bfill_d  = bfill_q;
    q_we     = 1'b0;
    b_we     = 1'b0;
    res_d    = '0;
    rem      = wtot_q - wdone_q;
    ndisc    = (NW'(rem) < NW'(bfill_q)) ? NW'(rem) : NW'(bfill_q);
    hsum     = (NW+1)'(bhead_q) + (NW+1)'(ndisc);
    rd_next  = (rdone_q < rtot_q) ? rdone_q + 8'd1 : rdone_q;

    if (item_pop_o) begin
      unique case (item_i.mode)
        MODE_SUBMIT: begin
          if (qfill_q >= QFW'(QUEUE_DEPTH)) begin
            res_d.request_status = ST_REJECTED;
          end else if (item_i.empty_xfer) begin
            res_d.request_status = ST_ACCEPTED;
            res_d.done_res       = 1'b1;
            res_d.success        = 1'b1;
          end else begin
            res_d.request_status = ST_ACCEPTED;
            if (!inprog_q) begin
              // queue is empty when nothing runs: load straight from the request
              addr_d   = item_i.dev_addr;
              wtot_d   = item_i.write_count;
              rtot_d   = item_i.read_count;
              wdone_d  = 8'd0;
              rdone_d  = 8'd0;
              phase_d  = PH_START;
              inprog_d = 1'b1;
              res_d.issue_start = 1'b1;
            end else begin
              q_we    = 1'b1;
              qtail_d = (qtail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : qtail_q + QW'(1);
              qfill_d = qfill_q + QFW'(1);
            end
          end
        end
        MODE_PUSH: begin
          if (bfill_q >= BFW'(BYTE_STORE_DEPTH)) begin
            res_d.request_status = ST_REJECTED;
          end else begin
            b_we    = 1'b1;
            btail_d = (btail_q == BW'(BYTE_STORE_DEPTH - 1)) ? '0 : btail_q + BW'(1);
            bfill_d = bfill_q + BFW'(1);
            res_d.request_status = ST_ACCEPTED;
          end
        end
        MODE_EVENT: begin
          unique case (phase_q)
            PH_START: begin
              if (!item_i.control_busy[CbStart]) begin
                res_d.command = CMD_TX;
                if (wtot_q != 8'd0) begin
                  phase_d = PH_ADDR_W;
                  res_d.tx_byte = {addr_q, 1'b0};
                end else begin
                  phase_d = PH_ADDR_R;
                  res_d.tx_byte = {addr_q, 1'b1};
                end
              end
            end
            PH_ADDR_W, PH_WRITE: begin
              if (!item_i.transmit_busy) begin
                if (item_i.nack_seen) begin
                  phase_d = PH_ERROR;
                  res_d.retrigger = 1'b1;
                end else if (wdone_q < wtot_q) begin
                  phase_d = PH_WRITE;
                  res_d.command = CMD_TX;
                  wdone_d = wdone_q + 8'd1;
                  if (bfill_q != '0) begin
                    res_d.tx_byte = b_head_data;
                    bhead_d = (bhead_q == BW'(BYTE_STORE_DEPTH - 1)) ?
                              '0 : bhead_q + BW'(1);
                    bfill_d = bfill_q - BFW'(1);
                  end
                end else if (rtot_q != 8'd0) begin
                  phase_d = PH_RESTART;
                  res_d.command = CMD_RESTART;
                end else begin
                  phase_d = PH_STOP;
                  res_d.command = CMD_STOP;
                end
              end
            end
            PH_RESTART: begin
              if (!item_i.control_busy[CbRestart]) begin
                phase_d = PH_ADDR_R;
                res_d.command = CMD_TX;
                res_d.tx_byte = {addr_q, 1'b1};
              end
            end
            PH_ADDR_R: begin
              if (!item_i.transmit_busy) begin
                if (item_i.nack_seen) begin
                  phase_d = PH_ERROR;
                  res_d.retrigger = 1'b1;
                end else begin
                  phase_d = PH_READ;
                  res_d.command = CMD_RCV;
                end
              end
            end
            PH_READ: begin
              if (item_i.rx_full) begin
                res_d.read_valid = 1'b1;
                res_d.read_byte  = item_i.data_byte;
                rdone_d = rd_next;
                res_d.command = (rd_next < rtot_q) ? CMD_ACK : CMD_NACK;
              end else if (!item_i.control_busy[CbAck] && !item_i.control_busy[CbRcv]) begin
                if (rdone_q < rtot_q) begin
                  res_d.command = CMD_RCV;
                end else begin
                  phase_d = PH_STOP;
                  res_d.command = CMD_STOP;
                end
              end
            end
            PH_STOP: begin
              if (!item_i.control_busy[CbStop]) begin
                phase_d = PH_DONE;
                res_d.retrigger = 1'b1;
              end
            end
            PH_DONE, PH_ERROR: begin
              res_d.done_res = 1'b1;
              res_d.success  = (phase_q == PH_DONE);
              if (phase_q == PH_ERROR) begin
                if (!item_i.control_busy[CbStop] && !item_i.stop_seen) begin
                  res_d.command = CMD_STOP;
                end
                // drop the unsent write bytes still held in the store
                wdone_d = wdone_q + ndisc[7:0];
                bhead_d = (hsum >= (NW+1)'(BYTE_STORE_DEPTH)) ?
                          BW'(hsum - (NW+1)'(BYTE_STORE_DEPTH)) : BW'(hsum);
                bfill_d = bfill_q - BFW'(ndisc);
              end
              phase_d = PH_IDLE;
              if (qfill_q == '0) begin
                inprog_d = 1'b0;
              end else begin
                addr_d   = q_head_data[22:16];
                wtot_d   = q_head_data[15:8];
                rtot_d   = q_head_data[7:0];
                wdone_d  = 8'd0;
                rdone_d  = 8'd0;
                phase_d  = PH_START;
                inprog_d = 1'b1;
                qhead_d  = (qhead_q == QW'(QUEUE_DEPTH - 1)) ? '0 : qhead_q + QW'(1);
                qfill_d  = qfill_q - QFW'(1);
                res_d.issue_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      res_d.busy_res = (phase_d != PH_IDLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      inprog_q    <= 1'b0;
      addr_q      <= '0;
      wtot_q      <= '0;
      wdone_q     <= '0;
      rtot_q      <= '0;
      rdone_q     <= '0;
      qhead_q     <= '0;
      qtail_q     <= '0;
      qfill_q     <= '0;
      bhead_q     <= '0;
      btail_q     <= '0;
      bfill_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      inprog_q <= inprog_d;
      addr_q   <= addr_d;
      wtot_q   <= wtot_d;
      wdone_q  <= wdone_d;
      rtot_q   <= rtot_d;
      rdone_q  <= rdone_d;
      qhead_q  <= qhead_d;
      qtail_q  <= qtail_d;
      qfill_q  <= qfill_d;
      bhead_q  <= bhead_d;
      btail_q  <= btail_d;
      bfill_q  <= bfill_d;
      if (item_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_idle_matches_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) == !inprog_q) else $error("phase and run flag disagree");
  a_queue_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !inprog_q |-> (qfill_q == '0)) else $error("requests queued while idle");
  a_qfill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qfill_q <= QFW'(QUEUE_DEPTH)) else $error("request queue overfilled");
  a_bfill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bfill_q <= BFW'(BYTE_STORE_DEPTH)) else $error("byte store overfilled");
  a_wdone_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wdone_q <= wtot_q) else $error("write count overrun");
`endif

endmodule

### rtl/i2c_master_transaction_sequencer.sv
// A result is registered: its item passes through the item queue, then the result register.
// Throughput: one item per cycle while the output is not stalled; each item is one state update in the back end.
// An output stall backs up into the two-entry item queue, then drops in_ready_o.
// Reset (rst_ni low, asynchronous) empties the queues and returns the phase to idle;
// store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer: I2C master write/read transaction sequencer
// Queues write/read transactions and steps them over bus engine events.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer import i2cs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH      = QueueDepthDef,
  parameter int unsigned BYTE_STORE_DEPTH = ByteDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [6:0] dev_addr_i,
  input  logic [7:0] write_count_i,
  input  logic [7:0] read_count_i,
  input  logic [7:0] data_byte_i,
  input  logic [4:0] control_busy_i,
  input  logic       transmit_busy_i,
  input  logic       nack_seen_i,
  input  logic       rx_full_i,
  input  logic       stop_seen_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] command_o,
  output logic [7:0] tx_byte_o,
  output logic       issue_start_o,
  output logic       read_valid_o,
  output logic [7:0] read_byte_o,
  output logic       done_res_o,
  output logic       success_o,
  output logic       retrigger_o,
  output logic       busy_res_o,
  output logic [1:0] request_status_o
);

  item_t   in_item, q_item;
  logic    q_valid, q_pop;
  result_t res;

  always_comb begin
    in_item               = '0;
    in_item.mode          = mode_e'(mode_i);
    in_item.dev_addr      = dev_addr_i;
    in_item.write_count   = write_count_i;
    in_item.read_count    = read_count_i;
    in_item.data_byte     = data_byte_i;
    in_item.control_busy  = control_busy_i;
    in_item.transmit_busy = transmit_busy_i;
    in_item.nack_seen     = nack_seen_i;
    in_item.rx_full       = rx_full_i;
    in_item.stop_seen     = stop_seen_i;
  end

  i2cs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .item_pop_i   (q_pop)
  );

  i2cs_back #(
    .QUEUE_DEPTH      (QUEUE_DEPTH),
    .BYTE_STORE_DEPTH (BYTE_STORE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign command_o        = res.command;
  assign tx_byte_o        = res.tx_byte;
  assign issue_start_o    = res.issue_start;
  assign read_valid_o     = res.read_valid;
  assign read_byte_o      = res.read_byte;
  assign done_res_o       = res.done_res;
  assign success_o        = res.success;
  assign retrigger_o      = res.retrigger;
  assign busy_res_o       = res.busy_res;
  assign request_status_o = res.request_status;

endmodule

### sim/i2c_master_transaction_sequencer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_checker: result predictor and scoreboard
// Watches the input and output channels, steps a behavioral copy of the
// sequencer on every input transfer and compares each output transfer.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_checker import i2cs_pkg::*; (
  input  logic       clk_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] mode_i,
  input  logic [6:0] dev_addr_i,
  input  logic [7:0] write_count_i,
  input  logic [7:0] read_count_i,
  input  logic [7:0] data_byte_i,
  input  logic [4:0] control_busy_i,
  input  logic       transmit_busy_i,
  input  logic       nack_seen_i,
  input  logic       rx_full_i,
  input  logic       stop_seen_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [2:0] command_i,
  input  logic [7:0] tx_byte_i,
  input  logic       issue_start_i,
  input  logic       read_valid_i,
  input  logic [7:0] read_byte_i,
  input  logic       done_res_i,
  input  logic       success_i,
  input  logic       retrigger_i,
  input  logic       busy_res_i,
  input  logic [1:0] request_status_i,
  output int         errors_o,
  output int         pending_o,
  output int         results_o,
  output int         completions_o
);

  phase_e      seq_phase;
  logic        active;
  logic [6:0]  cur_addr;
  logic [7:0]  wr_total, wr_done, rd_total, rd_done;
  logic [22:0] txn_q [QueueDepthDef];
  int unsigned txn_head, txn_tail, txn_fill;
  logic [7:0]  wbytes [ByteDepthDef];
  int unsigned wb_head, wb_tail, wb_fill;
  result_t     expected_q [$];

  initial begin
    seq_phase = PH_IDLE; active = 0;
    cur_addr = 0; wr_total = 0; wr_done = 0; rd_total = 0; rd_done = 0;
    txn_head = 0; txn_tail = 0; txn_fill = 0;
    wb_head = 0; wb_tail = 0; wb_fill = 0;
    errors_o = 0; pending_o = 0; results_o = 0; completions_o = 0;
  end

  function automatic logic [7:0] take_wbyte();
    logic [7:0] v;
    v = 8'd0;
    if (wb_fill > 0) begin
      v = wbytes[wb_head];
      wb_head = (wb_head + 1) % ByteDepthDef;
      wb_fill--;
    end
    return v;
  endfunction

  function automatic logic load_txn();
    logic [22:0] e;
    if (txn_fill == 0) begin
      active = 0;
      return 1'b0;
    end
    e = txn_q[txn_head];
    txn_head = (txn_head + 1) % QueueDepthDef;
    txn_fill--;
    cur_addr = e[22:16]; wr_total = e[15:8]; rd_total = e[7:0];
    wr_done = 0; rd_done = 0;
    seq_phase = PH_START; active = 1;
    return 1'b1;
  endfunction

  function automatic result_t sequence_item(item_t it);
    result_t r;
    r = '0;
    case (it.mode)
      MODE_SUBMIT: begin
        if (txn_fill >= QueueDepthDef) r.request_status = ST_REJECTED;
        else if (it.write_count == 0 && it.read_count == 0) begin
          r.request_status = ST_ACCEPTED; r.done_res = 1; r.success = 1;
        end else begin
          txn_q[txn_tail] = {it.dev_addr, it.write_count, it.read_count};
          txn_tail = (txn_tail + 1) % QueueDepthDef;
          txn_fill++;
          r.request_status = ST_ACCEPTED;
          if (!active) r.issue_start = load_txn();
        end
      end
      MODE_PUSH: begin
        if (wb_fill >= ByteDepthDef) r.request_status = ST_REJECTED;
        else begin
          wbytes[wb_tail] = it.data_byte;
          wb_tail = (wb_tail + 1) % ByteDepthDef;
          wb_fill++;
          r.request_status = ST_ACCEPTED;
        end
      end
      MODE_EVENT: begin
        case (seq_phase)
          PH_START: if (!it.control_busy[CbStart]) begin
            r.command = CMD_TX;
            if (wr_total > 0) begin
              seq_phase = PH_ADDR_W; r.tx_byte = {cur_addr, 1'b0};
            end else begin
              seq_phase = PH_ADDR_R; r.tx_byte = {cur_addr, 1'b1};
            end
          end
          PH_ADDR_W, PH_WRITE: if (!it.transmit_busy) begin
            if (it.nack_seen) begin
              seq_phase = PH_ERROR; r.retrigger = 1;
            end else if (wr_done < wr_total) begin
              seq_phase = PH_WRITE; r.command = CMD_TX;
              r.tx_byte = take_wbyte(); wr_done++;
            end else if (rd_total > 0) begin
              seq_phase = PH_RESTART; r.command = CMD_RESTART;
            end else begin
              seq_phase = PH_STOP; r.command = CMD_STOP;
            end
          end
          PH_RESTART: if (!it.control_busy[CbRestart]) begin
            seq_phase = PH_ADDR_R; r.command = CMD_TX; r.tx_byte = {cur_addr, 1'b1};
          end
          PH_ADDR_R: if (!it.transmit_busy) begin
            if (it.nack_seen) begin
              seq_phase = PH_ERROR; r.retrigger = 1;
            end else begin
              seq_phase = PH_READ; r.command = CMD_RCV;
            end
          end
          PH_READ: begin
            if (it.rx_full) begin
              r.read_valid = 1; r.read_byte = it.data_byte;
              if (rd_done < rd_total) rd_done++;
              r.command = (rd_done < rd_total) ? CMD_ACK : CMD_NACK;
            end else if (!it.control_busy[CbAck] && !it.control_busy[CbRcv]) begin
              if (rd_done < rd_total) r.command = CMD_RCV;
              else begin
                seq_phase = PH_STOP; r.command = CMD_STOP;
              end
            end
          end
          PH_STOP: if (!it.control_busy[CbStop]) begin
            seq_phase = PH_DONE; r.retrigger = 1;
          end
          PH_DONE: begin
            r.done_res = 1; r.success = 1; seq_phase = PH_IDLE;
            r.issue_start = load_txn();
          end
          PH_ERROR: begin
            if (!it.control_busy[CbStop] && !it.stop_seen) r.command = CMD_STOP;
            // drop the write bytes this transaction never sent
            while (wr_done < wr_total && wb_fill > 0) begin
              void'(take_wbyte());
              wr_done++;
            end
            r.done_res = 1; r.success = 0; seq_phase = PH_IDLE;
            r.issue_start = load_txn();
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.busy_res = (seq_phase != PH_IDLE);
    return r;
  endfunction

  always @(posedge clk_i) begin
    item_t   it;
    result_t got, exp_r;
    if (out_valid_i && out_ready_i) begin
      got = '{command: cmd_e'(command_i), tx_byte: tx_byte_i, issue_start: issue_start_i,
              read_valid: read_valid_i, read_byte: read_byte_i, done_res: done_res_i,
              success: success_i, retrigger: retrigger_i, busy_res: busy_res_i,
              request_status: status_e'(request_status_i)};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors_o++;
      end else begin
        exp_r = expected_q.pop_front();
        results_o++;
        if (got.done_res) completions_o++;
        if (got.command !== exp_r.command || got.tx_byte !== exp_r.tx_byte ||
            got.issue_start !== exp_r.issue_start || got.read_valid !== exp_r.read_valid ||
            got.read_byte !== exp_r.read_byte || got.done_res !== exp_r.done_res ||
            got.success !== exp_r.success || got.retrigger !== exp_r.retrigger ||
            got.busy_res !== exp_r.busy_res ||
            got.request_status !== exp_r.request_status) begin
          $display("%0t: mismatch cmd/tx/st/rv/rb/dn/ok/rt/bz/rs exp %0d %h %b %b %h %b %b %b %b %0d",
                   $time, exp_r.command, exp_r.tx_byte, exp_r.issue_start, exp_r.read_valid,
                   exp_r.read_byte, exp_r.done_res, exp_r.success, exp_r.retrigger,
                   exp_r.busy_res, exp_r.request_status);
          $display("%0t:                                   act %0d %h %b %b %h %b %b %b %b %0d",
                   $time, got.command, got.tx_byte, got.issue_start, got.read_valid,
                   got.read_byte, got.done_res, got.success, got.retrigger,
                   got.busy_res, got.request_status);
          errors_o++;
        end
      end
    end
    if (in_valid_i && in_ready_i) begin
      it = '0;
      it.mode = mode_e'(mode_i); it.dev_addr = dev_addr_i;
      it.write_count = write_count_i; it.read_count = read_count_i;
      it.data_byte = data_byte_i; it.control_busy = control_busy_i;
      it.transmit_busy = transmit_busy_i; it.nack_seen = nack_seen_i;
      it.rx_full = rx_full_i; it.stop_seen = stop_seen_i;
      expected_q.push_back(sequence_item(it));
    end
    pending_o = expected_q.size();
  end

endmodule

### sim/i2c_master_transaction_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_tb: top of the sequencer testbench
// Drives directed then random submits, pushes and bus events with bursty
// input and stalling output; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_tb;
  import i2cs_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_ready_i = 0;
  logic [1:0] mode_i = 0;
  logic [6:0] dev_addr_i = 0;
  logic [7:0] write_count_i = 0, read_count_i = 0, data_byte_i = 0;
  logic [4:0] control_busy_i = 0;
  logic transmit_busy_i = 0, nack_seen_i = 0, rx_full_i = 0, stop_seen_i = 0;
  logic in_ready_o, out_valid_o;
  logic [2:0] command_o;
  logic [7:0] tx_byte_o, read_byte_o;
  logic issue_start_o, read_valid_o, done_res_o, success_o, retrigger_o, busy_res_o;
  logic [1:0] request_status_o;
  int errors, pending, results, completions;
  int cycles = 0;
  int hold_off = 0;  // long receiver stall, in cycles
  int transfers = 0;

  always #10 clk_i = ~clk_i;

  i2c_master_transaction_sequencer u_dut (.*);

  i2c_master_transaction_sequencer_checker u_chk (
    .clk_i, .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .dev_addr_i, .write_count_i,
    .read_count_i, .data_byte_i, .control_busy_i, .transmit_busy_i, .nack_seen_i,
    .rx_full_i, .stop_seen_i, .out_valid_i(out_valid_o), .out_ready_i,
    .command_i(command_o), .tx_byte_i(tx_byte_o), .issue_start_i(issue_start_o),
    .read_valid_i(read_valid_o), .read_byte_i(read_byte_o), .done_res_i(done_res_o),
    .success_i(success_o), .retrigger_i(retrigger_o), .busy_res_i(busy_res_o),
    .request_status_i(request_status_o), .errors_o(errors), .pending_o(pending),
    .results_o(results), .completions_o(completions));

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall pattern, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 0;
    else if (hold_off > 0) begin
      out_ready_i <= 0;
      hold_off <= hold_off - 1;
    end else if (cycles % 300 < 60) out_ready_i <= 1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  task automatic send(input logic [1:0] m, input logic [6:0] a, input logic [7:0] wc,
                      input logic [7:0] rc, input logic [7:0] d, input logic [4:0] cb,
                      input logic txb, input logic nk, input logic rf, input logic sp);
    mode_i <= m; dev_addr_i <= a; write_count_i <= wc; read_count_i <= rc;
    data_byte_i <= d; control_busy_i <= cb; transmit_busy_i <= txb;
    nack_seen_i <= nk; rx_full_i <= rf; stop_seen_i <= sp;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    transfers++;
    @(negedge clk_i);
  endtask

  task automatic pause_gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic rand_event(input int p_good);
    logic [4:0] cb;
    cb = ($urandom_range(0, 99) < p_good) ? 5'd0 : 5'($urandom);
    send(MODE_EVENT, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), cb,
         ($urandom_range(0, 99) < 100 - p_good) ? 1'b1 : 1'b0,
         ($urandom_range(0, 19) == 0), ($urandom_range(0, 2) == 0),
         1'($urandom));
  endtask

  // one well-formed transaction: pushes, submit, then a run of events
  task automatic rand_transaction();
    int wc, rc, n;
    wc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
    rc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
    for (int i = 0; i < wc && i < 6; i++) begin
      send(MODE_PUSH, 0, 0, 0, 8'($urandom), 0, 0, 0, 0, 0);
      pause_gap();
    end
    send(MODE_SUBMIT, 7'($urandom), 8'(wc), 8'(rc), 0, 0, 0, 0, 0, 0);
    n = 4 + (wc < 8 ? wc : 8) + 2 * (rc < 8 ? rc : 8) + $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      rand_event(80);
      pause_gap();
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: empty submit, a write then read with extremes, then NACK path
    send(MODE_SUBMIT, 7'h7F, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0);
    send(MODE_EVENT, 0, 0, 0, 8'hFF, 5'h1F, 1, 1, 1, 1);  // event while idle
    send(2'd3, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 5'h1F, 1, 1, 1, 1);  // unused mode
    send(MODE_PUSH, 0, 0, 0, 8'hFF, 0, 0, 0, 0, 0);
    send(MODE_SUBMIT, 7'h7F, 8'd2, 8'd1, 0, 0, 0, 0, 0, 0);
    send(MODE_EVENT, 0, 0, 0, 0, 5'h01, 0, 0, 0, 0);  // start still pending
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 0, 0, 0, 0);  // address write
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 1, 0, 0, 0);  // transmit busy
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 0, 0, 0, 0);  // byte from store
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 0, 0, 0, 0);  // store empty byte
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 0, 0, 0, 0);  // restart
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 0, 0, 0, 0);  // address read
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 0, 0, 0, 0);  // receive
    send(MODE_EVENT, 0, 0, 0, 8'hA5, 5'h00, 0, 0, 1, 0);  // last byte
    send(MODE_EVENT, 0, 0, 0, 8'h5A, 5'h00, 0, 0, 1, 0);  // extra byte
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 0, 0, 0, 0);  // stop
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 0, 0, 0, 0);  // done
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 0, 0, 0, 0);  // completion
    send(MODE_PUSH, 0, 0, 0, 8'h00, 0, 0, 0, 0, 0);
    send(MODE_SUBMIT, 7'h00, 8'd255, 8'd0, 0, 0, 0, 0, 0, 0);
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 0, 1, 0, 0);  // nack
    send(MODE_EVENT, 0, 0, 0, 0, 5'h00, 0, 0, 0, 1);  // error with stop seen

    // fill both stores past full
    for (int i = 0; i < 66; i++) send(MODE_PUSH, 0, 0, 0, 8'($urandom), 0, 0, 0, 0, 0);
    for (int i = 0; i < 10; i++)
      send(MODE_SUBMIT, 7'($urandom), 8'd1, 8'($urandom), 0, 0, 0, 0, 0, 0);

    // long output hold-off while input keeps coming
    hold_off = 60;
    for (int i = 0; i < 20; i++) rand_event(80);

    // sender waits until everything is back
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);

    while (transfers < 1150) begin
      if ($urandom_range(0, 9) < 8) rand_transaction();
      else begin
        case ($urandom_range(0, 2))
          0: send(MODE_SUBMIT, 7'($urandom), 8'($urandom), 8'($urandom), 0, 0, 0, 0, 0, 0);
          1: send(MODE_PUSH, 0, 0, 0, 8'($urandom), 0, 0, 0, 0, 0);
          default: rand_event(30);
        endcase
      end
      pause_gap();
    end
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("covered %0d input transfers, %0d results, %0d completions",
             transfers, results, completions);
    if (errors == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
